// ===== rtl/phong_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the Phong point-light shading unit.
// Depends on nothing; used by phong_point_light_shading_unit.
package phong_pkg;

  localparam int COLOR_FRAC_BITS = 12;
  localparam int ACC_FRAC        = 24;
  localparam int OUT_SHIFT       = ACC_FRAC - COLOR_FRAC_BITS;
  localparam int FAC_STEPS       = 24;

  localparam logic [30:0] ONE30 = 31'h4000_0000;

  // configuration register indexes
  localparam logic [2:0] CFG_EYE_X     = 3'd0;
  localparam logic [2:0] CFG_EYE_Y     = 3'd1;
  localparam logic [2:0] CFG_EYE_Z     = 3'd2;
  localparam logic [2:0] CFG_AMBIENT   = 3'd3;
  localparam logic [2:0] CFG_DIFFUSE   = 3'd4;
  localparam logic [2:0] CFG_SPECULAR  = 3'd5;
  localparam logic [2:0] CFG_SHININESS = 3'd6;

  // destination of a normalized vector
  localparam logic [1:0] TGT_L = 2'd0;
  localparam logic [1:0] TGT_E = 2'd1;
  localparam logic [1:0] TGT_R = 2'd2;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_UPREP,
    ST_USQ,
    ST_USQRT,
    ST_UDIV_INIT,
    ST_UDIV,
    ST_URET,
    ST_DOT,
    ST_REFL,
    ST_PW_INIT,
    ST_PW_NORM,
    ST_PW_SQ,
    ST_PW_T,
    ST_PW_T2,
    ST_PW_EXP,
    ST_COL_AMB,
    ST_COL,
    ST_EMIT
  } state_t;

  typedef logic [FAC_STEPS-1:0][30:0] fac_tbl_t;

  // floor square root, bit by bit
  function automatic logic [63:0] isqrt64(input logic [63:0] val);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    v = val;
    r = '0;
    b = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // factor j is 2^(-2^-(j+1)) in Q1.30, each the truncated root of the one before
  function automatic fac_tbl_t fac_table();
    fac_tbl_t    t;
    logic [63:0] fac;
    fac = 64'h2000_0000;
    for (int j = 0; j < FAC_STEPS; j++) begin
      fac  = isqrt64(fac << 30);
      t[j] = fac[30:0];
    end
    return t;
  endfunction

  localparam fac_tbl_t FAC_TBL = fac_table();

  // channel c of a packed color, red first
  function automatic logic [15:0] chan(input logic [47:0] p, input logic [1:0] c);
    logic [15:0] v;
    case (c)
      2'd0:    v = p[47:32];
      2'd1:    v = p[31:16];
      default: v = p[15:0];
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/phong_point_light_shading_unit.sv =====
`timescale 1ns / 1ps
// Phong point-light shading: one light per input transfer, color out on the last light.
// Work is done step by step on a square-root step, a divide step and the one shared
// 33x33 multiplier; one item at a time, the next transfer is taken once the sequencer
// is back in idle.
// Reset (rst_n low, synchronous) clears the sequencer, output valid, accumulators and
// configuration (shininess 32.0, all else zero).
module phong_point_light_shading_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // surface_x, surface_y, surface_z, normal_x, normal_y, normal_z,
  // light_x, light_y, light_z, light_rgb (lowest bit up)
  input  logic [287:0] in_tdata,
  input  logic         in_tuser,   // first_light
  input  logic         in_tlast,   // last_light
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [47:0]  out_tdata,  // color_red, color_green, color_blue
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [47:0]  cfg_wdata
);

  phong_pkg::state_t state_r, state_nxt;

  logic signed [31:0] eye_r [3];
  logic [47:0] amb_r, dif_r, spec_r;
  logic [15:0] shin_r;

  logic signed [31:0] pos_r [3];
  logic signed [15:0] nrm_r [3];
  logic [47:0] lrgb_r;
  logic        first_r, last_r;

  logic signed [33:0] vec_r [3];
  logic        sgn_r [3];
  logic [29:0] m_r [3];
  logic [61:0] s_r;
  logic [63:0] sqv_r, sqr_r, sqb_r;
  logic [30:0] len_r;
  logic [31:0] rem_r;
  logic [30:0] nb_r, q_r;
  logic [1:0]  comp_r;
  logic signed [31:0] uvec_r [3];
  logic [1:0]  utgt_r;
  logic signed [31:0] lv_r [3], ev_r [3], rv_r [3];
  logic signed [65:0] acc_r;
  logic        dsel_r;
  logic [31:0] ndl_r, rde_r;
  logic [30:0] y_r;
  logic [4:0]  lz_r, n_r;
  logic [15:0] frac_r;
  logic [23:0] f_r;
  logic [30:0] rr_r, pw_r;
  logic [31:0] tmp_r;
  logic [31:0] cs_r [3];

  logic [1:0]  idx_r;
  logic [5:0]  cnt_r;
  logic        ph_r;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] p_r;

  logic        out_valid_r;
  logic [47:0] out_data_r;

  logic [1:0] iss_idx, prv_idx, cc;
  logic       accept, emit_load;
  phong_pkg::state_t col_start;

  assign iss_idx   = (idx_r == 2'd3) ? 2'd2 : idx_r;
  assign prv_idx   = (idx_r == 2'd0) ? 2'd0 : idx_r - 2'd1;
  assign cc        = (state_r == phong_pkg::ST_COL) ? cnt_r[3:2] : cnt_r[1:0];
  assign accept    = in_tvalid && in_tready;
  assign in_tready = (state_r == phong_pkg::ST_IDLE);
  assign col_start = first_r ? phong_pkg::ST_COL_AMB : phong_pkg::ST_COL;
  assign emit_load = (state_r == phong_pkg::ST_EMIT) && last_r && (!out_valid_r || out_tready);

  // normalize prep
  logic [33:0] mag [3];
  logic [33:0] mx;
  logic [2:0]  ksh;
  always_comb begin
    for (int i = 0; i < 3; i++) mag[i] = vec_r[i][33] ? 34'(-vec_r[i]) : 34'(vec_r[i]);
    mx = mag[0];
    if (mag[1] > mx) mx = mag[1];
    if (mag[2] > mx) mx = mag[2];
    if (mx[33])      ksh = 3'd4;
    else if (mx[32]) ksh = 3'd3;
    else if (mx[31]) ksh = 3'd2;
    else if (mx[30]) ksh = 3'd1;
    else             ksh = 3'd0;
  end

  // square-root step
  logic [63:0] sv_cur, sr_cur, sb_cur, srb, sv_n, sr_n;
  logic        sge;
  always_comb begin
    sv_cur = (cnt_r == 6'd0) ? {2'b0, s_r} : sqv_r;
    sr_cur = (cnt_r == 6'd0) ? 64'd0 : sqr_r;
    sb_cur = (cnt_r == 6'd0) ? 64'h4000_0000_0000_0000 : sqb_r;
    srb    = sr_cur + sb_cur;
    sge    = sv_cur >= srb;
    sv_n   = sge ? sv_cur - srb : sv_cur;
    sr_n   = sge ? (sr_cur >> 1) + sb_cur : sr_cur >> 1;
  end

  // divide step
  logic [32:0] dt;
  logic        dge;
  logic [30:0] dq, dqc;
  always_comb begin
    dt  = {rem_r, nb_r[30]};
    dge = dt >= {2'b0, len_r};
    dq  = {q_r[29:0], dge};
    if (len_r == 31'd0)               dqc = '0;
    else if (dq > phong_pkg::ONE30)   dqc = phong_pkg::ONE30;
    else                              dqc = dq;
  end

  // dot clamp and reflection term
  logic signed [65:0] dsum, pmag;
  logic [35:0] dsh;
  logic [31:0] dres;
  logic [32:0] rmag;
  logic signed [33:0] rsv, rval;
  always_comb begin
    dsum = acc_r + p_r;
    dsh  = dsum[65:30];
    if (dsum[65] || dsum == 66'sd0)  dres = '0;
    else if (dsh > 36'h8000_0000)    dres = 32'h8000_0000;
    else                             dres = dsh[31:0];
    pmag = p_r[65] ? -p_r : p_r;
    rmag = pmag[61:29];
    rsv  = p_r[65] ? -$signed({1'b0, rmag}) : $signed({1'b0, rmag});
    rval = rsv - 34'(lv_r[prv_idx]);
  end

  // power helpers
  logic [30:0] xc;
  logic [31:0] yy;
  logic [20:0] nl;
  logic [30:0] rr_f;
  always_comb begin
    xc   = (rde_r > {1'b0, phong_pkg::ONE30}) ? phong_pkg::ONE30 : rde_r[30:0];
    yy   = p_r[61:30];
    nl   = {lz_r, 16'b0} - {5'b0, frac_r};
    rr_f = f_r[23] ? p_r[60:30] : rr_r;
  end

  // accumulator saturating add
  logic [32:0] csum;
  always_comb begin
    csum = {1'b0, cs_r[cc]} + {3'b0, p_r[65:36]};
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      phong_pkg::ST_USQ: begin
        mul_a = $signed({3'b0, m_r[iss_idx]});
        mul_b = $signed({3'b0, m_r[iss_idx]});
      end
      phong_pkg::ST_DOT: begin
        if (dsel_r) begin
          mul_a = 33'(rv_r[iss_idx]);
          mul_b = 33'(ev_r[iss_idx]);
        end else begin
          mul_a = $signed({{2{nrm_r[iss_idx][15]}}, nrm_r[iss_idx], 15'b0});
          mul_b = 33'(lv_r[iss_idx]);
        end
      end
      phong_pkg::ST_REFL: begin
        mul_a = $signed({{2{nrm_r[iss_idx][15]}}, nrm_r[iss_idx], 15'b0});
        mul_b = $signed({1'b0, ndl_r});
      end
      phong_pkg::ST_PW_SQ: begin
        mul_a = $signed({2'b0, y_r});
        mul_b = $signed({2'b0, y_r});
      end
      phong_pkg::ST_PW_T: begin
        mul_a = $signed({12'b0, nl});
        mul_b = $signed({17'b0, shin_r});
      end
      phong_pkg::ST_PW_EXP: begin
        mul_a = $signed({2'b0, rr_r});
        mul_b = $signed({2'b0, phong_pkg::FAC_TBL[cnt_r[4:0]]});
      end
      phong_pkg::ST_COL_AMB: begin
        mul_a = $signed({17'b0, phong_pkg::chan(amb_r, cc)});
        mul_b = $signed({17'b0, phong_pkg::chan(dif_r, cc)});
      end
      phong_pkg::ST_COL: begin
        case (cnt_r[1:0])
          2'd0: begin
            mul_a = $signed({17'b0, phong_pkg::chan(dif_r, cc)});
            mul_b = $signed({17'b0, phong_pkg::chan(lrgb_r, cc)});
          end
          2'd1: begin
            mul_a = $signed({1'b0, tmp_r});
            mul_b = $signed({1'b0, ndl_r});
          end
          2'd2: begin
            mul_a = $signed({17'b0, phong_pkg::chan(spec_r, cc)});
            mul_b = $signed({17'b0, phong_pkg::chan(lrgb_r, cc)});
          end
          default: begin
            mul_a = $signed({1'b0, tmp_r});
            mul_b = $signed({2'b0, pw_r});
          end
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    p_r <= mul_a * mul_b;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      phong_pkg::ST_IDLE:      if (accept) state_nxt = phong_pkg::ST_UPREP;
      phong_pkg::ST_UPREP:     state_nxt = phong_pkg::ST_USQ;
      phong_pkg::ST_USQ:       if (idx_r == 2'd3) state_nxt = phong_pkg::ST_USQRT;
      phong_pkg::ST_USQRT:     if (cnt_r == 6'd31) state_nxt = phong_pkg::ST_UDIV_INIT;
      phong_pkg::ST_UDIV_INIT: state_nxt = phong_pkg::ST_UDIV;
      phong_pkg::ST_UDIV: begin
        if (cnt_r == 6'd30)
          state_nxt = (comp_r == 2'd2) ? phong_pkg::ST_URET : phong_pkg::ST_UDIV_INIT;
      end
      phong_pkg::ST_URET: begin
        state_nxt = (utgt_r == phong_pkg::TGT_L) ? phong_pkg::ST_UPREP : phong_pkg::ST_DOT;
      end
      phong_pkg::ST_DOT: begin
        if (idx_r == 2'd3) state_nxt = dsel_r ? phong_pkg::ST_PW_INIT : phong_pkg::ST_REFL;
      end
      phong_pkg::ST_REFL:      if (idx_r == 2'd3) state_nxt = phong_pkg::ST_UPREP;
      phong_pkg::ST_PW_INIT:   state_nxt = (xc == 31'd0) ? col_start : phong_pkg::ST_PW_NORM;
      phong_pkg::ST_PW_NORM:   if (y_r[30]) state_nxt = phong_pkg::ST_PW_SQ;
      phong_pkg::ST_PW_SQ:     if (ph_r && cnt_r == 6'd15) state_nxt = phong_pkg::ST_PW_T;
      phong_pkg::ST_PW_T:      state_nxt = phong_pkg::ST_PW_T2;
      phong_pkg::ST_PW_T2: begin
        state_nxt = (p_r[36:24] > 13'd30) ? col_start : phong_pkg::ST_PW_EXP;
      end
      phong_pkg::ST_PW_EXP:    if (ph_r && cnt_r == 6'd23) state_nxt = col_start;
      phong_pkg::ST_COL_AMB:   if (ph_r && cnt_r == 6'd2) state_nxt = phong_pkg::ST_COL;
      phong_pkg::ST_COL:       if (ph_r && cnt_r == 6'd11) state_nxt = phong_pkg::ST_EMIT;
      phong_pkg::ST_EMIT:      if (!last_r || emit_load) state_nxt = phong_pkg::ST_IDLE;
      default:                 state_nxt = phong_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= phong_pkg::ST_IDLE;
    else        state_r <= state_nxt;
  end

  // step counters
  always_ff @(posedge clk) begin
    if (!rst_n || state_nxt != state_r) begin
      cnt_r <= '0;
      idx_r <= '0;
      ph_r  <= 1'b0;
    end else begin
      ph_r  <= ~ph_r;
      idx_r <= idx_r + 2'd1;
      if (state_r == phong_pkg::ST_USQRT || state_r == phong_pkg::ST_UDIV || ph_r)
        cnt_r <= cnt_r + 6'd1;
    end
  end

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) eye_r[i] <= '0;
      amb_r  <= '0;
      dif_r  <= '0;
      spec_r <= '0;
      shin_r <= 16'h2000;
    end else if (cfg_we) begin
      case (cfg_index)
        phong_pkg::CFG_EYE_X:     eye_r[0] <= cfg_wdata[31:0];
        phong_pkg::CFG_EYE_Y:     eye_r[1] <= cfg_wdata[31:0];
        phong_pkg::CFG_EYE_Z:     eye_r[2] <= cfg_wdata[31:0];
        phong_pkg::CFG_AMBIENT:   amb_r    <= cfg_wdata;
        phong_pkg::CFG_DIFFUSE:   dif_r    <= cfg_wdata;
        phong_pkg::CFG_SPECULAR:  spec_r   <= cfg_wdata;
        phong_pkg::CFG_SHININESS: shin_r   <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // color accumulators
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) cs_r[i] <= '0;
    end else if (ph_r) begin
      if (state_r == phong_pkg::ST_COL_AMB) begin
        cs_r[cc] <= {6'b0, p_r[31:6]};
      end else if (state_r == phong_pkg::ST_COL && cnt_r[0]) begin
        cs_r[cc] <= csum[32] ? 32'hFFFF_FFFF : csum[31:0];
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      phong_pkg::ST_IDLE: begin
        if (accept) begin
          for (int i = 0; i < 3; i++) begin
            pos_r[i] <= in_tdata[32*i +: 32];
            nrm_r[i] <= in_tdata[96 + 16*i +: 16];
            vec_r[i] <= 34'($signed(in_tdata[144 + 32*i +: 32]))
                        - 34'($signed(in_tdata[32*i +: 32]));
          end
          lrgb_r  <= in_tdata[287:240];
          first_r <= in_tuser;
          last_r  <= in_tlast;
          utgt_r  <= phong_pkg::TGT_L;
        end
      end
      phong_pkg::ST_UPREP: begin
        for (int i = 0; i < 3; i++) begin
          m_r[i]   <= 30'(mag[i] >> ksh);
          sgn_r[i] <= vec_r[i][33];
        end
        comp_r <= '0;
      end
      phong_pkg::ST_USQ: begin
        s_r <= (idx_r == 2'd0) ? 62'd0 : s_r + {2'b0, p_r[59:0]};
      end
      phong_pkg::ST_USQRT: begin
        sqv_r <= sv_n;
        sqr_r <= sr_n;
        sqb_r <= sb_cur >> 2;
        len_r <= sr_n[30:0];
      end
      phong_pkg::ST_UDIV_INIT: begin
        rem_r <= {3'b0, m_r[comp_r][29:1]};
        nb_r  <= {m_r[comp_r][0], 30'b0};
        q_r   <= '0;
      end
      phong_pkg::ST_UDIV: begin
        rem_r <= dge ? 32'(dt - {2'b0, len_r}) : dt[31:0];
        q_r   <= dq;
        nb_r  <= nb_r << 1;
        if (cnt_r == 6'd30) begin
          uvec_r[comp_r] <= sgn_r[comp_r] ? -$signed({1'b0, dqc}) : $signed({1'b0, dqc});
          comp_r <= comp_r + 2'd1;
        end
      end
      phong_pkg::ST_URET: begin
        case (utgt_r)
          phong_pkg::TGT_L: begin
            for (int i = 0; i < 3; i++) begin
              lv_r[i]  <= uvec_r[i];
              vec_r[i] <= 34'(eye_r[i]) - 34'(pos_r[i]);
            end
            utgt_r <= phong_pkg::TGT_E;
          end
          phong_pkg::TGT_E: begin
            for (int i = 0; i < 3; i++) ev_r[i] <= uvec_r[i];
            dsel_r <= 1'b0;
          end
          default: begin
            for (int i = 0; i < 3; i++) rv_r[i] <= uvec_r[i];
            dsel_r <= 1'b1;
          end
        endcase
      end
      phong_pkg::ST_DOT: begin
        acc_r <= (idx_r == 2'd0) ? 66'sd0 : dsum;
        if (idx_r == 2'd3) begin
          if (dsel_r) rde_r <= dres;
          else        ndl_r <= dres;
        end
      end
      phong_pkg::ST_REFL: begin
        if (idx_r != 2'd0) vec_r[prv_idx] <= rval;
        utgt_r <= phong_pkg::TGT_R;
      end
      phong_pkg::ST_PW_INIT: begin
        y_r    <= xc;
        lz_r   <= '0;
        frac_r <= '0;
        if (xc == 31'd0) pw_r <= (shin_r == 16'd0) ? phong_pkg::ONE30 : 31'd0;
      end
      phong_pkg::ST_PW_NORM: begin
        if (!y_r[30]) begin
          y_r  <= y_r << 1;
          lz_r <= lz_r + 5'd1;
        end
      end
      phong_pkg::ST_PW_SQ: begin
        if (ph_r) begin
          frac_r <= {frac_r[14:0], yy[31]};
          y_r    <= yy[31] ? yy[31:1] : yy[30:0];
        end
      end
      phong_pkg::ST_PW_T2: begin
        n_r  <= p_r[28:24];
        f_r  <= p_r[23:0];
        rr_r <= phong_pkg::ONE30;
        if (p_r[36:24] > 13'd30) pw_r <= '0;
      end
      phong_pkg::ST_PW_EXP: begin
        if (ph_r) begin
          rr_r <= rr_f;
          f_r  <= f_r << 1;
          if (cnt_r == 6'd23) pw_r <= rr_f >> n_r;
        end
      end
      phong_pkg::ST_COL: begin
        if (ph_r && !cnt_r[0]) tmp_r <= p_r[31:0];
      end
      default: ;
    endcase
  end

  // output register
  logic [31:0] osh [3];
  logic [15:0] oval [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      osh[i]  = cs_r[i] >> phong_pkg::OUT_SHIFT;
      oval[i] = (osh[i] > 32'h0000_FFFF) ? 16'hFFFF : osh[i][15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) out_data_r <= {oval[2], oval[1], oval[0]};
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== dv/phong_point_light_shading_unit_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for phong_point_light_shading_unit: a fixed-point Phong
// shading predictor checks every color transfer. Depends on rtl/phong_pkg.sv and the RTL.
module phong_point_light_shading_unit_test;

  localparam longint UNIT30     = 64'sd1 << 30;
  localparam int     SETTLE     = 700;
  localparam longint CYCLE_CAP  = 6_000_000;

  typedef longint vec_t [3];

  typedef struct {
    logic [31:0] sp [3];
    logic [15:0] nv [3];
    logic [31:0] lp [3];
    logic [47:0] rgb;
    logic        first;
    logic        last;
  } light_t;

  typedef struct {
    logic [15:0] r, g, b;
  } color_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [287:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic in_tlast = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = phong_pkg::CFG_EYE_X;
  logic [47:0] cfg_wdata = '0;

  // predictor state
  longint      eye [3];
  logic [47:0] amb_rgb, dif_rgb, spc_rgb;
  logic [15:0] shine;
  logic [31:0] color_acc [3];

  color_t color_q [$];
  int errors = 0;
  int colors_seen = 0;
  int lights_sent = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  longint cycles = 0;

  phong_point_light_shading_unit u_dut (.*);

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("%0t timeout, %0d colors still pending", $time, color_q.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk)
    out_tready <= (stall_pct == 0) ? 1'b1 : ($urandom % 100 >= stall_pct);

  // color checker
  always @(posedge clk) begin
    color_t exp_c;
    if (rst_n && out_tvalid && out_tready) begin
      colors_seen++;
      if (color_q.size() == 0) begin
        errors++;
        $display("%0t unexpected color transfer %h", $time, out_tdata);
      end else begin
        exp_c = color_q.pop_front();
        if (out_tdata[15:0] !== exp_c.r || out_tdata[31:16] !== exp_c.g ||
            out_tdata[47:32] !== exp_c.b) begin
          errors++;
          $display("%0t color mismatch: expected r=%h g=%h b=%h, got r=%h g=%h b=%h",
                   $time, exp_c.r, exp_c.g, exp_c.b,
                   out_tdata[15:0], out_tdata[31:16], out_tdata[47:32]);
        end
      end
    end
  end

  function automatic longint unsigned root64(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic vec_t unit_vec(vec_t v);
    longint unsigned m [3];
    longint unsigned mx, s, len, q;
    vec_t o;
    int k;
    mx = 0;
    s = 0;
    k = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = (v[i] < 0) ? longint'(-v[i]) : longint'(v[i]);
      if (m[i] > mx) mx = m[i];
    end
    while ((mx >> k) >= UNIT30) k++;
    for (int i = 0; i < 3; i++) begin
      m[i] >>= k;
      s += m[i] * m[i];
    end
    len = root64(s);
    for (int i = 0; i < 3; i++) begin
      q = 0;
      if (len != 0) begin
        q = (m[i] << 30) / len;
        if (q > UNIT30) q = UNIT30;
      end
      o[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
    end
    return o;
  endfunction

  function automatic longint clamp_dot(vec_t a, vec_t b);
    longint s;
    s = a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
    if (s <= 0) return 0;
    s = s >>> 30;
    if (s > 2 * UNIT30) s = 2 * UNIT30;
    return s;
  endfunction

  function automatic longint unsigned spec_power(longint unsigned x, longint unsigned s);
    longint unsigned y, frac, nl, t, n, f, r, fac;
    int p;
    frac = 0;
    p = 30;
    if (x > UNIT30) x = UNIT30;
    if (x == 0) return (s == 0) ? UNIT30 : 0;
    while (((x >> p) & 1) == 0) p--;
    y = x << (30 - p);
    for (int i = 0; i < 16; i++) begin
      y = (y * y) >> 30;
      frac <<= 1;
      if (y >= (64'd1 << 31)) begin
        frac |= 1;
        y >>= 1;
      end
    end
    nl = (longint'(30 - p) << 16) - frac;
    t = nl * s;
    n = t >> 24;
    if (n > 30) return 0;
    f = t & ((64'd1 << 24) - 1);
    r = UNIT30;
    fac = 64'd1 << 29;
    for (int i = 23; i >= 0; i--) begin
      fac = root64(fac << 30);
      if ((f >> i) & 1) r = (r * fac) >> 30;
    end
    return r >> n;
  endfunction

  function automatic longint unsigned rgb_chan(logic [47:0] p, int c);
    return (p >> (32 - 16 * c)) & 48'hFFFF;
  endfunction

  function automatic void sat_add(int c, longint unsigned v);
    longint unsigned s;
    s = longint'(color_acc[c]) + v;
    color_acc[c] = (s > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  // shade one accepted light, queue a color on the last one
  function automatic void shade_light(light_t it);
    vec_t pos, nrm, d, lv, ev, rv;
    longint ndl, rde;
    longint unsigned pw, lc, v;
    color_t c;
    logic [15:0] ch [3];
    for (int i = 0; i < 3; i++) begin
      pos[i] = longint'($signed(it.sp[i]));
      nrm[i] = longint'($signed(it.nv[i])) * 32768;
    end
    for (int i = 0; i < 3; i++) d[i] = longint'($signed(it.lp[i])) - pos[i];
    lv = unit_vec(d);
    for (int i = 0; i < 3; i++) d[i] = eye[i] - pos[i];
    ev = unit_vec(d);
    ndl = clamp_dot(nrm, lv);
    for (int i = 0; i < 3; i++) d[i] = (2 * nrm[i] * ndl) / UNIT30 - lv[i];
    rv = unit_vec(d);
    rde = clamp_dot(rv, ev);
    pw = spec_power(rde, shine);
    if (it.first)
      for (int i = 0; i < 3; i++)
        color_acc[i] = 32'((rgb_chan(amb_rgb, i) * rgb_chan(dif_rgb, i)) >> 6);
    for (int i = 0; i < 3; i++) begin
      lc = rgb_chan(it.rgb, i);
      sat_add(i, ((rgb_chan(dif_rgb, i) * lc) * longint'(ndl)) >> 36);
      sat_add(i, ((rgb_chan(spc_rgb, i) * lc) * pw) >> 36);
    end
    if (it.last) begin
      for (int i = 0; i < 3; i++) begin
        v = color_acc[i] >> (phong_pkg::ACC_FRAC - phong_pkg::COLOR_FRAC_BITS);
        ch[i] = (v > 16'hFFFF) ? 16'hFFFF : v[15:0];
      end
      c.r = ch[0];
      c.g = ch[1];
      c.b = ch[2];
      color_q.push_back(c);
    end
  endfunction

  task automatic send_light(light_t it);
    if (idle_pct != 0 && $urandom % 100 < idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {it.rgb, it.lp[2], it.lp[1], it.lp[0], it.nv[2], it.nv[1], it.nv[0],
                 it.sp[2], it.sp[1], it.sp[0]};
    in_tuser <= it.first;
    in_tlast <= it.last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    lights_sent++;
    shade_light(it);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (color_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_reg(logic [2:0] idx, logic [47:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      phong_pkg::CFG_EYE_X:     eye[0] = longint'($signed(val[31:0]));
      phong_pkg::CFG_EYE_Y:     eye[1] = longint'($signed(val[31:0]));
      phong_pkg::CFG_EYE_Z:     eye[2] = longint'($signed(val[31:0]));
      phong_pkg::CFG_AMBIENT:   amb_rgb = val;
      phong_pkg::CFG_DIFFUSE:   dif_rgb = val;
      phong_pkg::CFG_SPECULAR:  spc_rgb = val;
      phong_pkg::CFG_SHININESS: shine = val[15:0];
      default: ;
    endcase
  endtask

  task automatic set_scene(logic [31:0] ex, logic [31:0] ey, logic [31:0] ez,
                           logic [47:0] a, logic [47:0] d, logic [47:0] s, logic [15:0] sh);
    set_reg(phong_pkg::CFG_EYE_X, {16'h0, ex});
    set_reg(phong_pkg::CFG_EYE_Y, {16'h0, ey});
    set_reg(phong_pkg::CFG_EYE_Z, {16'h0, ez});
    set_reg(phong_pkg::CFG_AMBIENT, a);
    set_reg(phong_pkg::CFG_DIFFUSE, d);
    set_reg(phong_pkg::CFG_SPECULAR, s);
    set_reg(phong_pkg::CFG_SHININESS, {32'h0, sh});
  endtask

  function automatic light_t make_light(int sx, int sy, int sz, int nx, int ny, int nz,
                                        int lx, int ly, int lz, logic [47:0] rgb,
                                        bit f, bit l);
    light_t it;
    it.sp = '{sx, sy, sz};
    it.nv = '{nx[15:0], ny[15:0], nz[15:0]};
    it.lp = '{lx, ly, lz};
    it.rgb = rgb;
    it.first = f;
    it.last = l;
    return it;
  endfunction

  function automatic logic [31:0] rand_coord();
    if ($urandom % 100 < 75) return $urandom_range(0, 32'h7F_FFFF) - 32'h40_0000;
    return $urandom;
  endfunction

  function automatic logic [47:0] rand_rgb();
    return 48'({$urandom, $urandom});
  endfunction

  function automatic light_t rand_light(bit f, bit l);
    light_t it;
    for (int i = 0; i < 3; i++) begin
      it.sp[i] = rand_coord();
      it.lp[i] = rand_coord();
      it.nv[i] = 16'($urandom);
    end
    if ($urandom % 100 < 50) begin
      // mostly-facing normal so lights and highlights contribute
      it.nv[2] = 16'($urandom_range(16'h6000, 16'h7FFF));
      it.nv[0] = 16'($urandom_range(0, 16'h3FFF) - 16'h2000);
      it.nv[1] = 16'($urandom_range(0, 16'h3FFF) - 16'h2000);
      it.lp[2] = it.sp[2] + $urandom_range(32'h1_0000, 32'h20_0000);
    end
    if ($urandom % 100 < 3) it.lp = it.sp;
    it.rgb = rand_rgb();
    it.first = f;
    it.last = l;
    return it;
  endfunction

  task automatic test_directed();
    logic [47:0] w;
    w = 48'h8000_8000_8000;
    set_scene(32'h14_0000, 32'h0, 32'h14_0000, 48'h2000_4000_6000, 48'h6000_5000_4000,
              48'h7FFF_7FFF_7FFF, 16'h2000);
    send_light(make_light(0, 0, 0, 0, 0, 32767, 0, 0, 32'hA_0000, w, 1, 1));
    send_light(make_light(0, 0, 0, 0, 0, 32767, 32'h5_0000, 0, 32'h5_0000, w, 1, 0));
    send_light(make_light(0, 0, 0, 0, 0, 32767, -32'h5_0000, 0, 32'h5_0000, w, 0, 1));
    // light sitting on the hit point
    send_light(make_light(32'h1_0000, 2, 3, 0, 32767, 0, 32'h1_0000, 2, 3, w, 1, 1));
    // extremes of position and normal
    send_light(make_light(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, -32768, 32767, -32768,
                          32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 48'hFFFF_FFFF_FFFF,
                          1, 1));
    send_light(make_light(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32767, 32767, 32767,
                          32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 48'hFFFF_FFFF_FFFF,
                          1, 1));
    // zero normal, back-facing light
    send_light(make_light(0, 0, 0, 0, 0, 0, 0, 0, 32'h1_0000, w, 1, 1));
    send_light(make_light(0, 0, 0, 0, 0, -32768, 0, 0, 32'h1_0000, w, 1, 1));
    // accumulator kept after emit, light without first
    send_light(make_light(0, 0, 0, 0, 0, 32767, 0, 0, 32'h2_0000, w, 0, 1));
    send_light(make_light(0, 0, 0, 0, 0, 32767, 0, 0, 32'h2_0000, w, 0, 0));
    send_light(make_light(0, 0, 0, 0, 0, 32767, 0, 0, 32'h2_0000, w, 0, 1));
    drain();
    // eye on the hit point, shininess zero: zero base of the power
    set_scene(0, 0, 0, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 16'h0);
    send_light(make_light(0, 0, 0, 0, 0, 32767, 0, 0, 32'h3_0000, 48'hFFFF_FFFF_FFFF, 1, 0));
    for (int i = 0; i < 6; i++)
      send_light(make_light(0, 0, 0, 0, 0, 32767, 0, 32'h1_0000, 32'h3_0000,
                            48'hFFFF_FFFF_FFFF, 0, i == 5));
    drain();
    set_reg(phong_pkg::CFG_SHININESS, 48'hFFFF);
    send_light(make_light(0, 0, 0, 0, 0, 32767, 0, 0, 32'h3_0000, w, 1, 1));
    drain();
    set_reg(phong_pkg::CFG_EYE_Z, 48'h3_0000);
    send_light(make_light(0, 0, 0, 0, 0, 32767, 0, 0, 32'h3_0000, w, 1, 1));
    send_light(make_light(0, 0, 0, 0, 0, 32767, 32'h100, 0, 32'h3_0000, w, 1, 1));
    drain();
  endtask

  task automatic test_random(int n, int idle, int stall, bit pause);
    int left, run;
    light_t it;
    idle_pct = idle;
    stall_pct = stall;
    left = n;
    while (left > 0) begin
      run = $urandom_range(1, 4);
      for (int i = 0; i < run && left > 0; i++) begin
        it = rand_light(i == 0, i == run - 1);
        if ($urandom % 100 < 8) it.first = $urandom;
        if ($urandom % 100 < 8) it.last = $urandom;
        send_light(it);
        left--;
      end
      if (pause && left == n / 2) begin
        drain();
        set_reg(phong_pkg::CFG_SHININESS, 48'($urandom_range(0, 16'h1000)));
      end
    end
    drain();
    idle_pct = 0;
    stall_pct = 0;
  endtask

  task automatic rand_scene(bit extreme);
    if (extreme)
      set_scene(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 48'hFFFF_FFFF_FFFF,
                48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 16'hFFFF);
    else
      set_scene(rand_coord(), rand_coord(), $urandom_range(32'h40_0000, 32'h100_0000),
                rand_rgb(), rand_rgb(), rand_rgb(),
                16'($urandom_range(16'h100, 16'h4000)));
  endtask

  initial begin
    eye = '{0, 0, 0};
    amb_rgb = '0;
    dif_rgb = '0;
    spc_rgb = '0;
    shine = 16'd8192;
    color_acc = '{0, 0, 0};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // reset values of the scene registers first
    send_light(make_light(0, 0, -32'h1_0000, 0, 0, 32767, 0, 0, 32'h2_0000, 48'h0, 1, 1));
    drain();
    test_directed();
    rand_scene(0);
    test_random(400, 0, 0, 0);
    rand_scene(0);
    test_random(400, 45, 0, 1);
    rand_scene(0);
    test_random(400, 0, 45, 0);
    rand_scene(1);
    test_random(100, 36, 36, 0);
    rand_scene(0);
    test_random(300, 36, 36, 0);
    $display("Shaded %0d light transfers into %0d colors over directed and random scenes,",
             lights_sent, colors_seen);
    $display("with sender gaps and receiver stalls; %0d mismatches.", errors);
    if (errors == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/phong_pkg.sv
rtl/phong_point_light_shading_unit.sv
dv/phong_point_light_shading_unit_test.sv
